@@ hw/rtl/bcs_pkg.sv @@
// ----------------------------------------------------------------------------
// bcs_pkg
// shared codes, drive levels and reset values of the ball collector sequencer
// ----------------------------------------------------------------------------
package bcs_pkg;

  typedef logic signed [7:0] drive_t;

  // default width of the millisecond timer
  localparam int TIMER_BITS_DEF = 16;

  // field widths
  localparam int REQ_W    = 3;
  localparam int TICK_W   = 8;
  localparam int BALL_W   = 10;
  localparam int TIME_W   = 16;
  localparam int MODE_W   = 2;
  localparam int PHASE_W  = 2;
  localparam int SIGN_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RUN     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MROLLER = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MRAISE  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_ASSIST  = 3'd5;

  // modes
  localparam logic [MODE_W-1:0] MODE_STANDARD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MROLLER  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MRAISE   = 2'd3;

  // standard-mode phases
  localparam logic [PHASE_W-1:0] PH_LOWERING = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WAITING  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WAITBALL = 2'd2;
  localparam logic [PHASE_W-1:0] PH_RAISING  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BALL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAISE_TIME     = 2'd2;

  // configuration reset values
  localparam logic [BALL_W-1:0] BALL_THRESHOLD_RST = 10'd350;
  localparam logic [TIME_W-1:0] SETTLE_TIME_RST    = 16'd500;
  localparam logic [TIME_W-1:0] RAISE_TIME_RST     = 16'd750;

  // drive levels in hundredths of full power
  localparam drive_t DRV_ZERO      = 8'sd0;
  localparam drive_t DRV_LOWER     = -8'sd40;
  localparam drive_t DRV_RAISE     = 8'sd60;
  localparam drive_t DRV_MRAISE_UP = 8'sd45;
  localparam drive_t DRV_ASSIST    = 8'sd30;
  localparam drive_t DRV_FULL      = 8'sd100;
  localparam drive_t DRV_FULL_NEG  = -8'sd100;

  // held signs
  localparam logic signed [SIGN_W-1:0] SIGN_ZERO = 2'sd0;
  localparam logic signed [SIGN_W-1:0] SIGN_POS  = 2'sd1;
  localparam logic signed [SIGN_W-1:0] SIGN_NEG  = -2'sd1;

endpackage

@@ hw/rtl/ball_collector_sequencer.sv @@
// ----------------------------------------------------------------------------
// ball_collector_sequencer
// command and control-tick sequencer for a ball collector lift and roller
// ----------------------------------------------------------------------------
//
//  channel  ports                      direction  one word
//  in       in_valid / in_stall        sink       a command or a control tick
//  out      out_valid / out_stall      source     lift, roller, mode, phase
//  cfg      cfg_wr_en / index / wdata  sink       one register write
//
//  one word a cycle while out_stall is low: an input register, then the mode
//  and phase logic into the result register
//  while the result waits, a word is still taken into an empty input register
//  a stalled result holds the input register; in_stall rises only then
//  synchronous active-low reset brings mode disabled, phase lowering,
//  timer stopped at zero and both drives at zero
//
module ball_collector_sequencer #(
  parameter int TIMER_BITS = bcs_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bcs_pkg::REQ_W-1:0]         in_req_type,
  input  logic [bcs_pkg::TICK_W-1:0]        in_tick_ms,
  input  logic                              in_lower_limit,
  input  logic [bcs_pkg::BALL_W-1:0]        in_ball_value,
  input  logic signed [bcs_pkg::SIGN_W-1:0] in_roller_power,
  input  logic signed [bcs_pkg::SIGN_W-1:0] in_raise_direction,
  // result words
  output logic                              out_valid,
  input  logic                              out_stall,
  output bcs_pkg::drive_t                   out_lift_drive,
  output bcs_pkg::drive_t                   out_roller_drive,
  output logic [bcs_pkg::MODE_W-1:0]        out_mode_now,
  output logic [bcs_pkg::PHASE_W-1:0]       out_phase_now,
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcs_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  // compare width covering both the timer and the time registers
  localparam int CMP_W = (TIMER_BITS > bcs_pkg::TIME_W) ? TIMER_BITS : bcs_pkg::TIME_W;

  // configuration registers
  logic [bcs_pkg::BALL_W-1:0] ball_threshold_r;
  logic [bcs_pkg::TIME_W-1:0] settle_time_r;
  logic [bcs_pkg::TIME_W-1:0] raise_time_r;

  // input register
  logic                              s1_valid_r;
  logic [bcs_pkg::REQ_W-1:0]         s1_req_r;
  logic [bcs_pkg::TICK_W-1:0]        s1_tick_r;
  logic                              s1_lower_r;
  logic [bcs_pkg::BALL_W-1:0]        s1_ball_r;
  logic signed [bcs_pkg::SIGN_W-1:0] s1_rpow_r;
  logic signed [bcs_pkg::SIGN_W-1:0] s1_rdir_r;

  // sequencer state
  logic [bcs_pkg::MODE_W-1:0]        mode_r, mode_nxt;
  logic [bcs_pkg::PHASE_W-1:0]       phase_r, phase_nxt;
  logic [TIMER_BITS-1:0]             elapsed_r, elapsed_nxt;
  logic                              timer_on_r, timer_on_nxt;
  logic signed [bcs_pkg::SIGN_W-1:0] held_rpow_r, held_rpow_nxt;
  logic                              raise_up_r, raise_up_nxt;
  bcs_pkg::drive_t                   lift_r, lift_nxt;
  bcs_pkg::drive_t                   roller_r, roller_nxt;

  // result register
  logic                              out_valid_r;
  bcs_pkg::drive_t                   out_lift_r;
  bcs_pkg::drive_t                   out_roller_r;
  logic [bcs_pkg::MODE_W-1:0]        out_mode_r;
  logic [bcs_pkg::PHASE_W-1:0]       out_phase_r;

  logic hold;      // result waits and is stalled
  logic in_take;   // input word accepted
  logic s1_fire;   // input register consumed this cycle

  // timer arithmetic
  logic [TIMER_BITS:0]   tick_sum;
  logic [TIMER_BITS-1:0] elapsed_adv;

  assign hold     = out_valid_r && out_stall;
  assign in_stall = s1_valid_r && hold;
  assign in_take  = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && !hold;

  // saturating timer advance
  assign tick_sum    = {1'b0, elapsed_r} + (TIMER_BITS+1)'(s1_tick_r);
  assign elapsed_adv = tick_sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : tick_sum[TIMER_BITS-1:0];

  // configuration writes; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ball_threshold_r <= bcs_pkg::BALL_THRESHOLD_RST;
      settle_time_r    <= bcs_pkg::SETTLE_TIME_RST;
      raise_time_r     <= bcs_pkg::RAISE_TIME_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == bcs_pkg::CFG_BALL_THRESHOLD) begin
        ball_threshold_r <= cfg_wdata[bcs_pkg::BALL_W-1:0];
      end
      if (cfg_index == bcs_pkg::CFG_SETTLE_TIME) begin
        settle_time_r <= cfg_wdata[bcs_pkg::TIME_W-1:0];
      end
      if (cfg_index == bcs_pkg::CFG_RAISE_TIME) begin
        raise_time_r <= cfg_wdata[bcs_pkg::TIME_W-1:0];
      end
    end
  end

  // input register: loads whenever it is empty or being consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r   <= in_req_type;
      s1_tick_r  <= in_tick_ms;
      s1_lower_r <= in_lower_limit;
      s1_ball_r  <= in_ball_value;
      s1_rpow_r  <= in_roller_power;
      s1_rdir_r  <= in_raise_direction;
    end
  end

  // next state for the word in the input register
  always_comb begin
    mode_nxt      = mode_r;
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    timer_on_nxt  = timer_on_r;
    held_rpow_nxt = held_rpow_r;
    raise_up_nxt  = raise_up_r;
    lift_nxt      = lift_r;
    roller_nxt    = roller_r;

    unique case (s1_req_r)
      bcs_pkg::REQ_TICK: begin
        if (timer_on_r) begin
          elapsed_nxt = elapsed_adv;
        end
        unique case (mode_r)
          bcs_pkg::MODE_STANDARD: begin
            timer_on_nxt = 1'b1;
            unique case (phase_r)
              bcs_pkg::PH_LOWERING: begin
                // lower limit high: bottom not reached yet
                if (s1_lower_r) begin
                  lift_nxt   = bcs_pkg::DRV_LOWER;
                  roller_nxt = bcs_pkg::DRV_ZERO;
                end else begin
                  phase_nxt = bcs_pkg::PH_WAITING;
                end
              end
              bcs_pkg::PH_WAITING: begin
                if (s1_ball_r < ball_threshold_r) begin
                  lift_nxt   = bcs_pkg::DRV_ZERO;
                  roller_nxt = bcs_pkg::DRV_FULL;
                end else begin
                  elapsed_nxt = '0;
                  phase_nxt   = bcs_pkg::PH_WAITBALL;
                end
              end
              bcs_pkg::PH_WAITBALL: begin
                if (CMP_W'(elapsed_nxt) < CMP_W'(settle_time_r)) begin
                  lift_nxt   = bcs_pkg::DRV_ZERO;
                  roller_nxt = bcs_pkg::DRV_FULL;
                end else begin
                  elapsed_nxt = '0;
                  phase_nxt   = bcs_pkg::PH_RAISING;
                end
              end
              default: begin
                if (CMP_W'(elapsed_nxt) < CMP_W'(raise_time_r)) begin
                  lift_nxt   = bcs_pkg::DRV_RAISE;
                  roller_nxt = bcs_pkg::DRV_FULL;
                end else begin
                  phase_nxt = bcs_pkg::PH_LOWERING;
                end
              end
            endcase
          end
          bcs_pkg::MODE_DISABLED: begin
            lift_nxt     = bcs_pkg::DRV_ZERO;
            roller_nxt   = bcs_pkg::DRV_ZERO;
            timer_on_nxt = 1'b0;
          end
          bcs_pkg::MODE_MROLLER: begin
            if (held_rpow_r == bcs_pkg::SIGN_POS) begin
              roller_nxt = bcs_pkg::DRV_FULL;
            end else if (held_rpow_r == bcs_pkg::SIGN_ZERO) begin
              roller_nxt = bcs_pkg::DRV_ZERO;
            end else begin
              roller_nxt = bcs_pkg::DRV_FULL_NEG;
            end
            lift_nxt     = bcs_pkg::DRV_ZERO;
            timer_on_nxt = 1'b0;
          end
          default: begin
            lift_nxt = raise_up_r ? bcs_pkg::DRV_MRAISE_UP : bcs_pkg::DRV_LOWER;
          end
        endcase
      end
      bcs_pkg::REQ_RUN: begin
        mode_nxt  = bcs_pkg::MODE_STANDARD;
        phase_nxt = bcs_pkg::PH_LOWERING;
      end
      bcs_pkg::REQ_MROLLER: begin
        // any negative pattern is held as minus one
        if (s1_rpow_r != bcs_pkg::SIGN_ZERO) begin
          mode_nxt      = bcs_pkg::MODE_MROLLER;
          held_rpow_nxt = s1_rpow_r[bcs_pkg::SIGN_W-1] ? bcs_pkg::SIGN_NEG : bcs_pkg::SIGN_POS;
        end
      end
      bcs_pkg::REQ_DISABLE: begin
        mode_nxt = bcs_pkg::MODE_DISABLED;
      end
      bcs_pkg::REQ_MRAISE: begin
        if (s1_rdir_r != bcs_pkg::SIGN_ZERO) begin
          mode_nxt     = bcs_pkg::MODE_MRAISE;
          raise_up_nxt = s1_rdir_r[bcs_pkg::SIGN_W-1];
        end
      end
      bcs_pkg::REQ_ASSIST: begin
        lift_nxt = bcs_pkg::DRV_ASSIST;
      end
      default: begin
        // unknown request: state unchanged, current drives reported
      end
    endcase
  end

  // state update, only when a word leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= bcs_pkg::MODE_DISABLED;
      phase_r     <= bcs_pkg::PH_LOWERING;
      elapsed_r   <= '0;
      timer_on_r  <= 1'b0;
      held_rpow_r <= bcs_pkg::SIGN_ZERO;
      raise_up_r  <= 1'b0;
      lift_r      <= bcs_pkg::DRV_ZERO;
      roller_r    <= bcs_pkg::DRV_ZERO;
    end else if (s1_fire) begin
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      timer_on_r  <= timer_on_nxt;
      held_rpow_r <= held_rpow_nxt;
      raise_up_r  <= raise_up_nxt;
      lift_r      <= lift_nxt;
      roller_r    <= roller_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!hold) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_lift_r   <= lift_nxt;
      out_roller_r <= roller_nxt;
      out_mode_r   <= mode_nxt;
      out_phase_r  <= phase_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lift_drive   = out_lift_r;
  assign out_roller_drive = out_roller_r;
  assign out_mode_now     = out_mode_r;
  assign out_phase_now    = out_phase_r;

endmodule

@@ dv/ball_collector_sequencer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ball_collector_sequencer_test
// self-checking bench for the lift and roller sequencer: a directed table
// of commands and ticks, then random command streams under several register
// settings, each result word checked against a typed-in value or a cycle-free
// predictor
module ball_collector_sequencer_test;
  import bcs_pkg::*;

  localparam int TMR_BITS = TIMER_BITS_DEF;
  localparam longint unsigned TMR_MAX = (64'd1 << TMR_BITS) - 1;

  // request codes the block does not know, and the register slot with no register
  localparam logic [REQ_W-1:0] REQ_BAD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_BAD7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // the one sign pattern with no positive twin
  localparam logic signed [SIGN_W-1:0] SIGN_NEG2 = 2'sb10;

  typedef struct packed {
    logic [REQ_W-1:0]         req;
    logic [TICK_W-1:0]        tick_ms;
    logic                     lower_limit;
    logic [BALL_W-1:0]        ball;
    logic signed [SIGN_W-1:0] roller_power;
    logic signed [SIGN_W-1:0] raise_dir;
  } cmd_word_t;

  typedef struct packed {
    drive_t              lift;
    drive_t              roller;
    logic [MODE_W-1:0]   mode;
    logic [PHASE_W-1:0]  phase;
  } status_t;

  // one row of the directed table: a word, and a typed-in result where it is obvious
  typedef struct packed {
    cmd_word_t w;
    logic      typed;
    status_t   exp;
  } cmd_row_t;

  localparam int NUM_ROWS = 26;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [REQ_W-1:0]         in_req_type = '0;
  logic [TICK_W-1:0]        in_tick_ms = '0;
  logic                     in_lower_limit = 1'b0;
  logic [BALL_W-1:0]        in_ball_value = '0;
  logic signed [SIGN_W-1:0] in_roller_power = '0;
  logic signed [SIGN_W-1:0] in_raise_direction = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  drive_t                   out_lift_drive;
  drive_t                   out_roller_drive;
  logic [MODE_W-1:0]        out_mode_now;
  logic [PHASE_W-1:0]       out_phase_now;

  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DAT_W-1:0]     cfg_wdata = '0;

  // predictor copy of the registers, reset values to start
  logic [BALL_W-1:0] thr_cfg = BALL_THRESHOLD_RST;
  logic [TIME_W-1:0] settle_cfg = SETTLE_TIME_RST;
  logic [TIME_W-1:0] raise_cfg = RAISE_TIME_RST;

  // predictor copy of the sequencer state
  logic [MODE_W-1:0]  mode_q = MODE_DISABLED;
  logic [PHASE_W-1:0] phase_q = PH_LOWERING;
  longint unsigned    tmr_ms = 0;
  logic               tmr_run = 1'b0;
  int                 held_sign = 0;
  logic               raise_up_q = 1'b0;
  drive_t             lift_q = DRV_ZERO;
  drive_t             roller_q = DRV_ZERO;

  status_t  status_due[$];    // result words owed by the block, oldest first
  int       mismatch_cnt = 0;
  logic     idle_on = 1'b1;   // random gaps and stalls allowed
  int       stall_left = 0;
  cmd_row_t dir_tab [NUM_ROWS];

  ball_collector_sequencer #(
    .TIMER_BITS(TMR_BITS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_tick_ms        (in_tick_ms),
    .in_lower_limit    (in_lower_limit),
    .in_ball_value     (in_ball_value),
    .in_roller_power   (in_roller_power),
    .in_raise_direction(in_raise_direction),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_lift_drive    (out_lift_drive),
    .out_roller_drive  (out_roller_drive),
    .out_mode_now      (out_mode_now),
    .out_phase_now     (out_phase_now),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #10 clk = ~clk;

  // advance the predicted sequencer by one word and report its drives
  function automatic status_t step_sequencer(input cmd_word_t w);
    status_t s;
    case (w.req)
      REQ_TICK: begin
        // the timer counts first, then the mode acts on the new value
        if (tmr_run) begin
          tmr_ms = tmr_ms + w.tick_ms;
          if (tmr_ms > TMR_MAX) tmr_ms = TMR_MAX;
        end
        case (mode_q)
          MODE_STANDARD: begin
            tmr_run = 1'b1;
            // a tick that moves the phase leaves the drives alone
            case (phase_q)
              PH_LOWERING: begin
                if (w.lower_limit) begin
                  lift_q = DRV_LOWER;
                  roller_q = DRV_ZERO;
                end else begin
                  phase_q = PH_WAITING;
                end
              end
              PH_WAITING: begin
                if (w.ball < thr_cfg) begin
                  lift_q = DRV_ZERO;
                  roller_q = DRV_FULL;
                end else begin
                  tmr_ms = 0;
                  phase_q = PH_WAITBALL;
                end
              end
              PH_WAITBALL: begin
                if (tmr_ms < settle_cfg) begin
                  lift_q = DRV_ZERO;
                  roller_q = DRV_FULL;
                end else begin
                  tmr_ms = 0;
                  phase_q = PH_RAISING;
                end
              end
              default: begin
                if (tmr_ms < raise_cfg) begin
                  lift_q = DRV_RAISE;
                  roller_q = DRV_FULL;
                end else begin
                  phase_q = PH_LOWERING;
                end
              end
            endcase
          end
          MODE_DISABLED: begin
            lift_q = DRV_ZERO;
            roller_q = DRV_ZERO;
            tmr_run = 1'b0;
          end
          MODE_MROLLER: begin
            roller_q = drive_t'(100 * held_sign);
            lift_q = DRV_ZERO;
            tmr_run = 1'b0;
          end
          default: begin
            // manual raise keeps the roller and the timer as they are
            lift_q = raise_up_q ? DRV_MRAISE_UP : DRV_LOWER;
          end
        endcase
      end
      REQ_RUN: begin
        mode_q = MODE_STANDARD;
        phase_q = PH_LOWERING;
      end
      REQ_MROLLER: begin
        if (w.roller_power != SIGN_ZERO) begin
          mode_q = MODE_MROLLER;
          held_sign = (w.roller_power < 0) ? -1 : 1;
        end
      end
      REQ_DISABLE: mode_q = MODE_DISABLED;
      REQ_MRAISE: begin
        if (w.raise_dir != SIGN_ZERO) begin
          mode_q = MODE_MRAISE;
          raise_up_q = (w.raise_dir < 0);
        end
      end
      REQ_ASSIST: lift_q = DRV_ASSIST;
      default: ;
    endcase
    s.lift = lift_q;
    s.roller = roller_q;
    s.mode = mode_q;
    s.phase = phase_q;
    return s;
  endfunction

  // mostly ticks, with enough run commands to keep standard mode busy
  function automatic cmd_word_t rand_word();
    cmd_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.tick_ms = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    w.lower_limit = 1'($urandom);
    w.ball = 10'($urandom);
    w.roller_power = 2'($urandom);
    w.raise_dir = 2'($urandom);
    if (pick < 78) w.req = REQ_TICK;
    else if (pick < 86) w.req = REQ_RUN;
    else if (pick < 89) w.req = REQ_MROLLER;
    else if (pick < 91) w.req = REQ_DISABLE;
    else if (pick < 94) w.req = REQ_MRAISE;
    else if (pick < 97) w.req = REQ_ASSIST;
    else w.req = (pick < 99) ? REQ_BAD6 : REQ_BAD7;
    return w;
  endfunction

  // present one word, maybe after a gap, and book its result once taken
  task automatic send_word(input cmd_word_t w, input logic typed, input status_t typed_exp);
    status_t s;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= w.req;
    in_tick_ms <= w.tick_ms;
    in_lower_limit <= w.lower_limit;
    in_ball_value <= w.ball;
    in_roller_power <= w.roller_power;
    in_raise_direction <= w.raise_dir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    s = step_sequencer(w);
    status_due.push_back(typed ? typed_exp : s);
  endtask

  // write all three registers, plus a write to the empty slot that must be ignored
  task automatic write_regs(input logic [CFG_DAT_W-1:0] thr, input logic [CFG_DAT_W-1:0] settle,
                            input logic [CFG_DAT_W-1:0] rise);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BALL_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= CFG_SETTLE_TIME;
    cfg_wdata <= settle;
    @(posedge clk);
    cfg_index <= CFG_RAISE_TIME;
    cfg_wdata <= rise;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= CFG_DAT_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr_cfg = thr[BALL_W-1:0];
    settle_cfg = settle;
    raise_cfg = rise;
  endtask

  // stop sending and let every owed word come out, within a bound
  task automatic drain_results();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (status_due.size() != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    // two-stage pipe; let it settle before the registers move
    repeat (4) @(posedge clk);
  endtask

  // receiver side: random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check: every taken word against the oldest owed one
  always @(posedge clk) begin : result_check
    status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        $error("result word with none owed: lift %0d roller %0d mode %0d phase %0d",
               out_lift_drive, out_roller_drive, out_mode_now, out_phase_now);
        mismatch_cnt++;
      end else begin
        want = status_due.pop_front();
        if (out_lift_drive !== want.lift) begin
          $error("lift_drive: expected %0d, actual %0d", want.lift, out_lift_drive);
          mismatch_cnt++;
        end
        if (out_roller_drive !== want.roller) begin
          $error("roller_drive: expected %0d, actual %0d", want.roller, out_roller_drive);
          mismatch_cnt++;
        end
        if (out_mode_now !== want.mode) begin
          $error("mode_now: expected %0d, actual %0d", want.mode, out_mode_now);
          mismatch_cnt++;
        end
        if (out_phase_now !== want.phase) begin
          $error("phase_now: expected %0d, actual %0d", want.phase, out_phase_now);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    cmd_word_t w;
    int rnd;

    // req, tick_ms, lower_limit, ball, roller_power, raise_dir | typed, expected drives
    dir_tab = '{
      // fresh from reset: disabled, and a tick with every field at its top
      '{'{REQ_TICK, 8'd255, 1'b1, 10'd1023, SIGN_NEG, SIGN_NEG}, 1'b1,
        '{DRV_ZERO, DRV_ZERO, MODE_DISABLED, PH_LOWERING}},
      // unknown request changes nothing
      '{'{REQ_BAD6, 8'd0, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b1,
        '{DRV_ZERO, DRV_ZERO, MODE_DISABLED, PH_LOWERING}},
      // assisted raise sets the lift even while disabled
      '{'{REQ_ASSIST, 8'd0, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b1,
        '{DRV_ASSIST, DRV_ZERO, MODE_DISABLED, PH_LOWERING}},
      // zero direction leaves the mode alone
      '{'{REQ_MRAISE, 8'd0, 1'b0, 10'd0, SIGN_POS, SIGN_ZERO}, 1'b1,
        '{DRV_ASSIST, DRV_ZERO, MODE_DISABLED, PH_LOWERING}},
      '{'{REQ_TICK, 8'd0, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b1,
        '{DRV_ZERO, DRV_ZERO, MODE_DISABLED, PH_LOWERING}},
      // positive direction means lowering in manual raise
      '{'{REQ_MRAISE, 8'd7, 1'b1, 10'd5, SIGN_ZERO, SIGN_POS}, 1'b1,
        '{DRV_ZERO, DRV_ZERO, MODE_MRAISE, PH_LOWERING}},
      '{'{REQ_TICK, 8'd1, 1'b1, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b1,
        '{DRV_LOWER, DRV_ZERO, MODE_MRAISE, PH_LOWERING}},
      // direction of minus two counts as negative
      '{'{REQ_MRAISE, 8'd0, 1'b0, 10'd0, SIGN_ZERO, SIGN_NEG2}, 1'b1,
        '{DRV_LOWER, DRV_ZERO, MODE_MRAISE, PH_LOWERING}},
      '{'{REQ_TICK, 8'd2, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b1,
        '{DRV_MRAISE_UP, DRV_ZERO, MODE_MRAISE, PH_LOWERING}},
      // zero roller power leaves the mode alone
      '{'{REQ_MROLLER, 8'd0, 1'b0, 10'd0, SIGN_ZERO, SIGN_POS}, 1'b1,
        '{DRV_MRAISE_UP, DRV_ZERO, MODE_MRAISE, PH_LOWERING}},
      // roller power of minus two holds as minus one
      '{'{REQ_MROLLER, 8'd0, 1'b0, 10'd0, SIGN_NEG2, SIGN_ZERO}, 1'b1,
        '{DRV_MRAISE_UP, DRV_ZERO, MODE_MROLLER, PH_LOWERING}},
      '{'{REQ_TICK, 8'd3, 1'b1, 10'd1023, SIGN_ZERO, SIGN_ZERO}, 1'b1,
        '{DRV_ZERO, DRV_FULL_NEG, MODE_MROLLER, PH_LOWERING}},
      '{'{REQ_MROLLER, 8'd0, 1'b0, 10'd0, SIGN_POS, SIGN_ZERO}, 1'b1,
        '{DRV_ZERO, DRV_FULL_NEG, MODE_MROLLER, PH_LOWERING}},
      '{'{REQ_TICK, 8'd4, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b1,
        '{DRV_ZERO, DRV_FULL, MODE_MROLLER, PH_LOWERING}},
      '{'{REQ_RUN, 8'd0, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b1,
        '{DRV_ZERO, DRV_FULL, MODE_STANDARD, PH_LOWERING}},
      '{'{REQ_BAD7, 8'd255, 1'b1, 10'd1023, SIGN_NEG, SIGN_NEG}, 1'b1,
        '{DRV_ZERO, DRV_FULL, MODE_STANDARD, PH_LOWERING}},
      // one full collect cycle at the reset settings, threshold edge included
      '{'{REQ_TICK, 8'd0, 1'b1, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b0, '0},
      '{'{REQ_TICK, 8'd0, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b0, '0},
      '{'{REQ_TICK, 8'd10, 1'b0, 10'd349, SIGN_ZERO, SIGN_ZERO}, 1'b0, '0},
      '{'{REQ_TICK, 8'd10, 1'b0, 10'd350, SIGN_ZERO, SIGN_ZERO}, 1'b0, '0},
      '{'{REQ_TICK, 8'd255, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b0, '0},
      '{'{REQ_TICK, 8'd255, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b0, '0},
      '{'{REQ_TICK, 8'd255, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b0, '0},
      '{'{REQ_TICK, 8'd255, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b0, '0},
      '{'{REQ_TICK, 8'd240, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b0, '0},
      '{'{REQ_DISABLE, 8'd0, 1'b0, 10'd0, SIGN_ZERO, SIGN_ZERO}, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at the reset register values
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].exp);
    drain_results();

    // bottom of every register: any ball counts, no settle and no raise time
    write_regs('0, '0, '0);
    repeat (120) send_word(rand_word(), 1'b0, '0);
    drain_results();

    // top of every register, threshold data with bits past its width
    write_regs('1, '1, '1);
    w = rand_word();
    w.req = REQ_RUN;
    send_word(w, 1'b0, '0);
    w = rand_word();
    w.req = REQ_TICK;
    w.lower_limit = 1'b0;
    send_word(w, 1'b0, '0);
    // sit in the waiting phase long enough to run the timer into its ceiling
    repeat (262) begin
      w = rand_word();
      w.req = REQ_TICK;
      w.tick_ms = 8'd255;
      w.ball = 10'($urandom_range(0, 1022));
      send_word(w, 1'b0, '0);
    end
    // ball at full scale finally meets the top threshold
    w = rand_word();
    w.req = REQ_TICK;
    w.ball = 10'd1023;
    send_word(w, 1'b0, '0);
    repeat (60) send_word(rand_word(), 1'b0, '0);
    drain_results();

    // mid-range settings so that full collect cycles come around often
    repeat (3) begin
      write_regs(CFG_DAT_W'($urandom_range(0, 1023)), CFG_DAT_W'($urandom_range(0, 800)),
                 CFG_DAT_W'($urandom_range(0, 800)));
      repeat (80) send_word(rand_word(), 1'b0, '0);
      drain_results();
    end

    // last stretch at full rate on both sides
    idle_on = 1'b0;
    rnd = $urandom_range(0, 600);
    write_regs(CFG_DAT_W'($urandom_range(0, 1023)), CFG_DAT_W'(rnd),
               CFG_DAT_W'($urandom_range(0, 600)));
    repeat (120) send_word(rand_word(), 1'b0, '0);
    drain_results();

    if (status_due.size() != 0) begin
      $error("%0d result words never arrived", status_due.size());
    end
    if (mismatch_cnt == 0 && status_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
